/* design/stdet_pkg.sv */
// ----------------------------------------------------------------------------
// stdet_pkg: shared types and constants of the sustained tone detector
// Holds the bin and result payload types, register reset values and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package stdet_pkg;

	localparam int MAG_W     = 16;
	localparam int BIN_W     = 8;
	localparam int CNT_W     = 8;
	localparam int BINS_DEFAULT = 256;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Register reset values.
	localparam logic [MAG_W-1:0] THRESHOLD_RESET = 16'd800;
	localparam logic [CNT_W-1:0] LIMIT_RESET     = 8'd30;
	localparam logic [BIN_W-1:0] TOLERANCE_RESET = 8'd3;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_PEAK_THRESHOLD  = 2'd0,
		REG_SUSTAIN_LIMIT   = 2'd1,
		REG_INDEX_TOLERANCE = 2'd2,
		REG_UNUSED          = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [MAG_W-1:0] bin_magnitude;
		logic             frame_last;
	} bin_item_t;

	typedef struct packed {
		logic [BIN_W-1:0] peak_bin;
		logic [MAG_W-1:0] peak_level;
		logic             short_event;
		logic             long_event;
		logic             onset;
		logic             pitch_rose;
		logic [BIN_W-1:0] recognized_bin;
	} tone_result_t;

endpackage

/* design/sustained_tone_detector_core.sv */
// ----------------------------------------------------------------------------
// sustained_tone_detector_core: peak search and sustained tone tracking
// Finds the strongest bin of each spectrum frame and tracks whether the
// peak stays on one pitch for enough frames to raise a long event.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  bin       in         bin_valid/bin_ready   bin_data (bin_item_t)
//  res       out        res_valid/res_ready   res_data (tone_result_t)
//  apb       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One bin transaction is taken every cycle while no frame-end bin stalls in the
// input register. The result of a frame is presented once its last bin has left
// the input register and loaded the result register. Only a frame-end bin waits
// on the result register; other bins always pass. arst_n clears all control and
// tracking state and loads the register reset values.
module sustained_tone_detector_core
	import stdet_pkg::*;
#(
	parameter int BINS = BINS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_ready,
	input  bin_item_t            bin_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output tone_result_t         res_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam int POS_W = $clog2(BINS + 1);
	localparam logic [POS_W-1:0] POS_END = POS_W'(BINS);

	logic [MAG_W-1:0] threshold_q;
	logic [CNT_W-1:0] limit_q;
	logic [BIN_W-1:0] tolerance_q;

	logic             valid_s1;
	bin_item_t        item_s1;

	logic [POS_W-1:0] pos_q;
	logic [MAG_W-1:0] run_level_q;
	logic [BIN_W-1:0] run_bin_q;
	logic [BIN_W-1:0] tracked_q;
	logic [CNT_W-1:0] count_q;
	logic             long_q;
	logic [BIN_W-1:0] last_rec_q;
	logic [BIN_W-1:0] cur_rec_q;

	logic             res_valid_s2;
	tone_result_t     res_data_s2;

	logic             advance_s1;
	logic             take_peak;
	logic [MAG_W-1:0] level_n;
	logic [BIN_W-1:0] peak_n;
	logic             short_n;
	logic [BIN_W-1:0] seeded;
	logic [BIN_W-1:0] gap;
	logic [BIN_W-1:0] tracked_n;
	logic [CNT_W-1:0] count_n;
	logic             long_n;
	logic             onset_n;
	logic             rose_n;
	logic [BIN_W-1:0] cur_rec_n;
	logic [BIN_W-1:0] last_rec_n;
	logic             apb_write;
	reg_index_t       reg_sel;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_sel   = reg_index_t'(paddr[3:2]);
	assign apb_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			limit_q     <= LIMIT_RESET;
			tolerance_q <= TOLERANCE_RESET;
		end else if (apb_write) begin
			case (reg_sel)
				REG_PEAK_THRESHOLD:  threshold_q <= pwdata[MAG_W-1:0];
				REG_SUSTAIN_LIMIT:   limit_q     <= pwdata[CNT_W-1:0];
				REG_INDEX_TOLERANCE: tolerance_q <= pwdata[BIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PEAK_THRESHOLD:  prdata = PDATA_W'(threshold_q);
			REG_SUSTAIN_LIMIT:   prdata = PDATA_W'(limit_q);
			REG_INDEX_TOLERANCE: prdata = PDATA_W'(tolerance_q);
			default:             prdata = '0;
		endcase
	end

	// A frame-end bin needs a free result register; other bins never wait.
	assign advance_s1 = valid_s1 && (!item_s1.frame_last || !res_valid_s2 || res_ready);
	assign bin_ready  = !valid_s1 || advance_s1;

	always_comb begin
		// Peak search including the bin in the input register.
		take_peak = (pos_q != '0) && (pos_q < POS_END)
			&& (item_s1.bin_magnitude > run_level_q);
		level_n   = take_peak ? item_s1.bin_magnitude : run_level_q;
		peak_n    = take_peak ? BIN_W'(pos_q) : run_bin_q;

		// Pitch tracking at frame end.
		short_n   = level_n > threshold_q;
		seeded    = (tracked_q == '0) ? peak_n : tracked_q;
		gap       = (seeded > peak_n) ? seeded - peak_n : peak_n - seeded;
		tracked_n = tracked_q;
		count_n   = count_q;
		if (short_n) begin
			if (gap < tolerance_q) begin
				tracked_n = peak_n;
				if (count_q != COUNT_MAX)
					count_n = count_q + 1'b1;
			end else begin
				tracked_n = '0;
			end
		end else begin
			count_n = '0;
		end

		cur_rec_n  = cur_rec_q;
		last_rec_n = last_rec_q;
		long_n     = 1'b0;
		onset_n    = 1'b0;
		rose_n     = 1'b0;
		if (count_n > limit_q) begin
			cur_rec_n = tracked_n;
			long_n    = 1'b1;
			if (!long_q) begin
				onset_n    = 1'b1;
				rose_n     = !(last_rec_q > tracked_n);
				last_rec_n = tracked_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bin_ready) begin
			valid_s1 <= bin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_ready)
			item_s1 <= bin_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			run_level_q <= '0;
			run_bin_q   <= '0;
			tracked_q   <= '0;
			count_q     <= '0;
			long_q      <= 1'b0;
			last_rec_q  <= '0;
			cur_rec_q   <= '0;
		end else if (advance_s1) begin
			if (item_s1.frame_last) begin
				pos_q       <= '0;
				run_level_q <= '0;
				run_bin_q   <= '0;
				tracked_q   <= tracked_n;
				count_q     <= count_n;
				long_q      <= long_n;
				last_rec_q  <= last_rec_n;
				cur_rec_q   <= cur_rec_n;
			end else begin
				run_level_q <= level_n;
				run_bin_q   <= peak_n;
				if (pos_q < POS_END)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance_s1 && item_s1.frame_last) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && item_s1.frame_last) begin
			res_data_s2.peak_bin       <= peak_n;
			res_data_s2.peak_level     <= level_n;
			res_data_s2.short_event    <= short_n;
			res_data_s2.long_event     <= long_n;
			res_data_s2.onset          <= onset_n;
			res_data_s2.pitch_rose     <= rose_n;
			res_data_s2.recognized_bin <= long_n ? cur_rec_n : '0;
		end
	end

	assign res_valid = res_valid_s2;
	assign res_data  = res_data_s2;

`ifndef SYNTHESIS
	a_onset_in_long: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_data_s2.onset |-> res_data_s2.long_event)
		else $error("onset reported without a long event");

	a_rose_needs_onset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_data_s2.pitch_rose |-> res_data_s2.onset)
		else $error("pitch direction reported outside an onset");

	a_rec_needs_long: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && (res_data_s2.recognized_bin != '0) |-> res_data_s2.long_event)
		else $error("recognized bin reported without a long event");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_END)
		else $error("bin position ran past the frame length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stalled frame-end transaction was lost");
`endif

endmodule

/* tb/tb_sustained_tone_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sustained_tone_detector_core: self-checking bench for the tone detector
// Streams spectrum frames into the core with random idle cycles on both
// channels and checks every frame result against a cycle-free tracker model.
// Covers peak search edge cases, threshold and tolerance extremes, tracker
// clearing, overlong frames, count saturation, backpressure and random tones.
// ----------------------------------------------------------------------------
module tb_sustained_tone_detector_core;
	import stdet_pkg::*;

	localparam int BINS         = BINS_DEFAULT;
	localparam int HOLD_CYCLES  = 150;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               bin_valid = 1'b0;
	logic               bin_ready;
	bin_item_t          bin_data = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	tone_result_t       res_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	sustained_tone_detector_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bin_valid(bin_valid),
		.bin_ready(bin_ready),
		.bin_data(bin_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Tracker model state and its copy of the registers.
	logic [MAG_W-1:0] cfg_threshold = THRESHOLD_RESET;
	logic [CNT_W-1:0] cfg_limit     = LIMIT_RESET;
	logic [BIN_W-1:0] cfg_tolerance = TOLERANCE_RESET;
	int               frame_pos     = 0;
	logic [MAG_W-1:0] best_level    = '0;
	logic [BIN_W-1:0] best_bin      = '0;
	logic [BIN_W-1:0] follow_bin    = '0;
	logic [CNT_W-1:0] stable_frames = '0;
	logic             long_on       = 1'b0;
	logic [BIN_W-1:0] prev_recog    = '0;
	logic [BIN_W-1:0] cur_recog     = '0;

	tone_result_t pending_tones[$];
	tone_result_t want_tone;
	int           mismatch_count = 0;
	int           items_sent = 0;
	int           quiet_cycles = 0;
	bit           idle_en = 1'b1;
	bit           hold_request = 1'b0;

	// Advances the tracker by one bin; returns 1 when the bin closes a frame.
	function automatic bit track_bin(input logic [MAG_W-1:0] mag, input logic last,
			output tone_result_t tone);
		logic [BIN_W-1:0] gap;
		tone = '0;
		if (frame_pos >= 1 && frame_pos < BINS && mag > best_level) begin
			best_level = mag;
			best_bin   = frame_pos[BIN_W-1:0];
		end
		if (frame_pos < BINS)
			frame_pos++;
		if (!last)
			return 1'b0;

		tone.peak_bin    = best_bin;
		tone.peak_level  = best_level;
		tone.short_event = best_level > cfg_threshold;
		if (tone.short_event) begin
			if (follow_bin == 0)
				follow_bin = best_bin;
			gap = (follow_bin > best_bin) ? follow_bin - best_bin : best_bin - follow_bin;
			if (gap < cfg_tolerance) begin
				if (stable_frames < COUNT_MAX)
					stable_frames++;
				follow_bin = best_bin;
			end else begin
				follow_bin = '0;
			end
		end else begin
			stable_frames = '0;
		end

		if (stable_frames > cfg_limit) begin
			cur_recog = follow_bin;
			if (!long_on) begin
				long_on         = 1'b1;
				tone.onset      = 1'b1;
				tone.pitch_rose = !(prev_recog > cur_recog);
				prev_recog      = cur_recog;
			end
		end else begin
			long_on = 1'b0;
		end
		tone.long_event     = long_on;
		tone.recognized_bin = long_on ? cur_recog : '0;

		frame_pos  = 0;
		best_level = '0;
		best_bin   = '0;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Result checker: each result transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_tones.size() == 0) begin
				flag_mismatch("unexpected result", 32'(res_data.peak_bin), 0);
			end else begin
				want_tone = pending_tones.pop_front();
				if (res_data.peak_bin !== want_tone.peak_bin)
					flag_mismatch("peak_bin", 32'(res_data.peak_bin),
						32'(want_tone.peak_bin));
				if (res_data.peak_level !== want_tone.peak_level)
					flag_mismatch("peak_level", 32'(res_data.peak_level),
						32'(want_tone.peak_level));
				if (res_data.short_event !== want_tone.short_event)
					flag_mismatch("short_event", 32'(res_data.short_event),
						32'(want_tone.short_event));
				if (res_data.long_event !== want_tone.long_event)
					flag_mismatch("long_event", 32'(res_data.long_event),
						32'(want_tone.long_event));
				if (res_data.onset !== want_tone.onset)
					flag_mismatch("onset", 32'(res_data.onset), 32'(want_tone.onset));
				if (res_data.pitch_rose !== want_tone.pitch_rose)
					flag_mismatch("pitch_rose", 32'(res_data.pitch_rose),
						32'(want_tone.pitch_rose));
				if (res_data.recognized_bin !== want_tone.recognized_bin)
					flag_mismatch("recognized_bin", 32'(res_data.recognized_bin),
						32'(want_tone.recognized_bin));
			end
		end
	end

	// Watchdog on cycles with no transaction on either stream.
	always @(posedge clk) begin
		if (!arst_n || (bin_valid && bin_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** sustained_tone_detector_core: FAILED **");
			$finish;
		end
	end

	// Result sink: random stalls, or one long hold-off on request.
	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ready <= !(idle_en && $urandom_range(0, 99) < 25);
			end
			@(posedge clk);
		end
	end

	task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last);
		tone_result_t tone;
		while (idle_en && $urandom_range(0, 99) < 25) begin
			bin_valid <= 1'b0;
			@(posedge clk);
		end
		bin_valid <= 1'b1;
		bin_data  <= {mag, last};
		@(posedge clk);
		while (!bin_ready) @(posedge clk);
		if (track_bin(mag, last, tone))
			pending_tones.push_back(tone);
		items_sent++;
	endtask

	// Frame with one strict peak at peak_pos and weaker noise elsewhere.
	task automatic send_tone_frame(input int len, input int peak_pos, input int level);
		int i;
		int mag;
		for (i = 0; i < len; i++) begin
			mag = (i == peak_pos) ? level : ((level > 0) ? $urandom_range(0, level - 1) : 0);
			send_bin(mag[MAG_W-1:0], i == len - 1);
		end
	endtask

	task automatic send_noise_frame(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_bin(16'($urandom_range(0, 65535)), i == len - 1);
	endtask

	// Stops the bin stream until every predicted result has been taken.
	task automatic drain();
		bin_valid <= 1'b0;
		while (pending_tones.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PEAK_THRESHOLD:  cfg_threshold = value[MAG_W-1:0];
			REG_SUSTAIN_LIMIT:   cfg_limit     = value[CNT_W-1:0];
			REG_INDEX_TOLERANCE: cfg_tolerance = value[BIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int threshold, input int limit, input int tolerance);
		drain();
		write_reg(REG_PEAK_THRESHOLD, threshold);
		write_reg(REG_SUSTAIN_LIMIT, limit);
		write_reg(REG_INDEX_TOLERANCE, tolerance);
	endtask

	// Peak search at reset settings: bin 0 ignored, first maximum wins, threshold is strict.
	task automatic test_peak_search();
		send_bin(16'hFFFF, 1'b1);
		send_bin(16'hFFFF, 1'b0);
		send_bin(16'h0000, 1'b0);
		send_bin(16'hFFFF, 1'b1);
		send_bin(16'd0, 1'b0);
		send_bin(16'd801, 1'b0);
		send_bin(16'd801, 1'b0);
		send_bin(16'd800, 1'b1);
		send_bin(16'd0, 1'b0);
		send_bin(16'd800, 1'b1);
		send_bin(16'd0, 1'b0);
		send_bin(16'd0, 1'b0);
		send_bin(16'd0, 1'b1);
	endtask

	task automatic test_thresholds();
		// With zero tolerance no distance qualifies, so the count never rises.
		configure(0, 0, 0);
		send_tone_frame(3, 1, 40);
		send_tone_frame(3, 2, 40);
		// Nothing can exceed the top threshold.
		configure(65535, 0, 2);
		send_tone_frame(3, 2, 65535);
		send_tone_frame(3, 2, 65535);
	endtask

	// Onset, tracker clearing while the count is held, and both pitch directions.
	task automatic test_tracking();
		configure(0, 0, 2);
		send_tone_frame(6, 5, 500);
		send_tone_frame(13, 12, 500);
		send_tone_frame(4, 3, 500);
		send_tone_frame(2, 1, 0);
		send_tone_frame(3, 2, 500);
		send_tone_frame(2, 1, 0);
		send_tone_frame(10, 9, 300);
	endtask

	// Bins past the end of the search window must not affect the peak.
	task automatic test_long_frame();
		int i;
		int mag;
		configure(100, 1, 3);
		for (i = 0; i < 300; i++) begin
			mag = (i == 255) ? 5000 : ((i == 280) ? 65535 : $urandom_range(0, 50));
			send_bin(mag[MAG_W-1:0], i == 299);
		end
		send_tone_frame(BINS, BINS - 1, 5000);
		send_tone_frame(BINS + 1, BINS - 1, 6000);
	endtask

	// The count saturates at its top; a limit at that top never raises a long event.
	task automatic test_saturation();
		int n;
		configure(100, 254, 3);
		for (n = 0; n < 258; n++) begin
			send_bin(16'd0, 1'b0);
			send_bin(16'd1000, 1'b1);
		end
		configure(100, 255, 3);
		for (n = 0; n < 3; n++) begin
			send_bin(16'd0, 1'b0);
			send_bin(16'd1000, 1'b1);
		end
	endtask

	task automatic test_backpressure();
		int n;
		configure(100, 2, 3);
		idle_en = 1'b0;
		hold_request = 1'b1;
		for (n = 0; n < 40; n++)
			send_tone_frame(3, 1 + n % 2, 2000);
		drain();
		idle_en = 1'b1;
	endtask

	// Mostly tones that wander within the tolerance, with jumps and noise frames.
	task automatic test_random();
		int phase;
		int start;
		int n;
		int frames;
		int base;
		int jit;
		int pos;
		int len;
		int lvl;
		int pick;
		phase = 0;
		base  = 5;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			idle_en = (phase != 2);
			case (phase % 5)
				1: configure($urandom_range(0, 3000), $urandom_range(0, 5), 255);
				3: configure($urandom_range(0, 65535), $urandom_range(0, 254),
					$urandom_range(1, 255));
				default: configure($urandom_range(0, 3000), $urandom_range(0, 5),
					$urandom_range(1, 6));
			endcase
			frames = $urandom_range(4, 8);
			for (n = 0; n < frames; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					drain();
				if (pick < 15) begin
					send_noise_frame($urandom_range(1, 24));
				end else begin
					if ($urandom_range(0, 99) < 15)
						base = $urandom_range(1, 60);
					jit = (cfg_tolerance > 1) ? cfg_tolerance - 1 : 0;
					if (jit > 4)
						jit = 4;
					pos = base + $urandom_range(0, 2 * jit) - jit;
					if (pos < 1)
						pos = 1;
					if (pos > 60)
						pos = 60;
					if ($urandom_range(0, 99) < 2)
						len = $urandom_range(250, 270);
					else
						len = pos + 1 + $urandom_range(0, 6);
					if ($urandom_range(0, 99) < 85)
						lvl = cfg_threshold + 1 + $urandom_range(0, 3000);
					else
						lvl = $urandom_range(0, cfg_threshold);
					if (lvl > 65535)
						lvl = 65535;
					send_tone_frame(len, pos, lvl);
				end
			end
			phase++;
		end
		idle_en = 1'b1;
	endtask

	initial begin : main
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_peak_search();
		test_thresholds();
		test_tracking();
		test_long_frame();
		test_saturation();
		test_backpressure();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("** sustained_tone_detector_core: PASSED **");
		else
			$display("** sustained_tone_detector_core: FAILED **");
		$finish;
	end

endmodule
